// ----- hdl/evr_pkg.sv -----
// Shared types and constants for the Euler vertex rotator.
// Holds the trig register format, configuration register indexes and pipeline depth.
// No dependencies.
package evr_pkg;

  // Trig registers are signed Q2.14, 16 bits wide
  localparam int TRIG_W     = 16;
  // One extra bit so that a negated sine stays exact
  localparam int TRIG_EXT_W = TRIG_W + 1;

  // Configuration port index width
  localparam int CFG_IDX_W = 3;

  // Register stages from input acceptance to result register
  localparam int EVR_DEPTH  = 6;
  localparam int PIPE_CNT_W = $clog2(EVR_DEPTH + 1);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COS_PITCH = 3'd0,
    REG_SIN_PITCH = 3'd1,
    REG_COS_YAW   = 3'd2,
    REG_SIN_YAW   = 3'd3,
    REG_COS_ROLL  = 3'd4,
    REG_SIN_ROLL  = 3'd5
  } cfg_reg_e;

  // Cosine and sine of one rotation
  typedef struct packed {
    logic signed [TRIG_W-1:0] cos_v;
    logic signed [TRIG_W-1:0] sin_v;
  } evr_trig_t;

endpackage

// ----- hdl/evr_if.sv -----
// Valid/ready channel interfaces for vertices in and rotated vertices out.
// Depends on nothing; width follows the coordinate width parameter.
interface evr_vertex_if #(parameter int W = 32);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] x;
  logic signed [W-1:0] y;
  logic signed [W-1:0] z;

  modport source (output valid, output x, output y, output z, input ready);
  modport sink   (input valid, input x, input y, input z, output ready);
endinterface

interface evr_rotated_if #(parameter int W = 32);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] x;
  logic signed [W-1:0] y;
  logic signed [W-1:0] z;
  logic                saturated;

  modport source (output valid, output x, output y, output z, output saturated, input ready);
  modport sink   (input valid, input x, input y, input z, input saturated, output ready);
endinterface

// ----- hdl/evr_givens.sv -----
// One plane rotation: p = a*cos - b*sin, q = a*sin + b*cos, each product rounded.
// Two register stages (products, then rounded sums with saturation). Uses evr_pkg.
module evr_givens
  import evr_pkg::*;
#(
  parameter int CW = 32,
  parameter int FB = 14
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  evr_trig_t            trig,
  input  logic                 i_valid,
  output logic                 i_ready,
  input  logic signed [CW-1:0] i_a,
  input  logic signed [CW-1:0] i_b,
  input  logic signed [CW-1:0] i_pass,
  input  logic                 i_sat,
  output logic                 o_valid,
  input  logic                 o_ready,
  output logic signed [CW-1:0] o_p,
  output logic signed [CW-1:0] o_q,
  output logic signed [CW-1:0] o_pass,
  output logic                 o_sat
);

  localparam int PW = CW + TRIG_EXT_W;
  localparam int RW = PW - FB;
  localparam int SW = RW + 1;
  localparam logic signed [PW-1:0] HALF = {{(PW-FB){1'b0}}, 1'b1, {(FB-1){1'b0}}};
  localparam logic signed [CW-1:0] SAT_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] SAT_MIN = {1'b1, {(CW-1){1'b0}}};

  // Round to nearest, ties upward: add half, floor shift
  function automatic logic signed [RW-1:0] rnd(input logic signed [PW-1:0] prod);
    logic signed [PW-1:0] tmp;
    tmp = prod + HALF;
    return tmp[PW-1:FB];
  endfunction

  // Clip to CW bits; top bit of the result is the clip flag
  function automatic logic [CW:0] clip(input logic signed [SW-1:0] sum);
    logic [SW-CW:0] upper;
    upper = sum[SW-1:CW-1];
    if (&upper || ~|upper) begin
      return {1'b0, sum[CW-1:0]};
    end else if (sum[SW-1]) begin
      return {1'b1, SAT_MIN};
    end else begin
      return {1'b1, SAT_MAX};
    end
  endfunction

  logic signed [TRIG_EXT_W-1:0] cos_e, sin_e, nsin_e;
  logic en1, en2;

  logic                 v1_r, v2_r;
  logic signed [PW-1:0] ac_r, nbs_r, as_r, bc_r;
  logic signed [CW-1:0] pass1_r, pass2_r;
  logic                 sat1_r, sat2_r;
  logic signed [CW-1:0] p_r, q_r;

  logic signed [RW-1:0] ac_rn, nbs_rn, as_rn, bc_rn;
  logic signed [SW-1:0] p_sum, q_sum;
  logic [CW:0]          p_clip, q_clip;

  // Extend trig values, negate sine exactly
  assign cos_e  = {trig.cos_v[TRIG_W-1], trig.cos_v};
  assign sin_e  = {trig.sin_v[TRIG_W-1], trig.sin_v};
  assign nsin_e = -sin_e;

  // Stage enables: a stage moves when empty or when the next one moves
  assign en2     = !v2_r || o_ready;
  assign en1     = !v1_r || en2;
  assign i_ready = en1;

  // Stage 1: the four products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && i_valid) begin
      ac_r    <= i_a * cos_e;
      nbs_r   <= i_b * nsin_e;
      as_r    <= i_a * sin_e;
      bc_r    <= i_b * cos_e;
      pass1_r <= i_pass;
      sat1_r  <= i_sat;
    end
  end

  // Stage 2: round each product, add, clip
  assign ac_rn  = rnd(ac_r);
  assign nbs_rn = rnd(nbs_r);
  assign as_rn  = rnd(as_r);
  assign bc_rn  = rnd(bc_r);
  assign p_sum  = {ac_rn[RW-1], ac_rn} + {nbs_rn[RW-1], nbs_rn};
  assign q_sum  = {as_rn[RW-1], as_rn} + {bc_rn[RW-1], bc_rn};
  assign p_clip = clip(p_sum);
  assign q_clip = clip(q_sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1_r) begin
      p_r     <= p_clip[CW-1:0];
      q_r     <= q_clip[CW-1:0];
      pass2_r <= pass1_r;
      sat2_r  <= sat1_r | p_clip[CW] | q_clip[CW];
    end
  end

  assign o_valid = v2_r;
  assign o_p     = p_r;
  assign o_q     = q_r;
  assign o_pass  = pass2_r;
  assign o_sat   = sat2_r;

endmodule

// ----- hdl/euler_vertex_rotator_top.sv -----
// Euler vertex rotator: pitch, yaw and roll rotation of a streamed vertex.
// Depends on evr_pkg, evr_if.sv and evr_givens.
//
// Usage:
//   in_vtx carries one vertex (x, y, z, signed Q16.16) per transaction.
//   out_rot carries the rotated vertex and a flag set when any intermediate
//   or final coordinate was clipped to the coordinate range.
//   cfg_we/cfg_index/cfg_data load the six Q2.14 trig registers
//   (cos/sin of pitch, yaw, roll, index 0..5); other indexes are ignored.
//   Write them only while no vertex is in flight.
// Pipeline: three plane rotations of two register stages each (multiply,
//   then round/add/clip).
// Throughput: one vertex per cycle while out_rot is not stalled; each stage holds
//   one vertex and takes the next whenever it is empty or the stage after it moves.
// Reset: all stages empty, trig registers set to the identity rotation.
// Stall: a held result stays on out_rot; earlier stages keep filling until
//   every stage is full, and only then is in_vtx.ready dropped.
module euler_vertex_rotator_top
  import evr_pkg::*;
#(
  parameter int COORD_WIDTH    = 32,
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic                   clk,
  input  logic                   rst_n,
  evr_vertex_if.sink             in_vtx,
  evr_rotated_if.source          out_rot,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [TRIG_W-1:0]      cfg_data
);

  localparam int CW = COORD_WIDTH;
  localparam logic [TRIG_W-1:0] TRIG_ONE = TRIG_W'(1 << TRIG_FRAC_BITS);

  evr_trig_t pitch_r, yaw_r, roll_r;

  // Load trig registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_r <= '{cos_v: TRIG_ONE, sin_v: '0};
      yaw_r   <= '{cos_v: TRIG_ONE, sin_v: '0};
      roll_r  <= '{cos_v: TRIG_ONE, sin_v: '0};
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COS_PITCH: pitch_r.cos_v <= cfg_data;
        REG_SIN_PITCH: pitch_r.sin_v <= cfg_data;
        REG_COS_YAW:   yaw_r.cos_v   <= cfg_data;
        REG_SIN_YAW:   yaw_r.sin_v   <= cfg_data;
        REG_COS_ROLL:  roll_r.cos_v  <= cfg_data;
        REG_SIN_ROLL:  roll_r.sin_v  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic                 s1_valid, s1_ready, s1_sat;
  logic signed [CW-1:0] y1, z1, s1_x;
  logic                 s2_valid, s2_ready, s2_sat;
  logic signed [CW-1:0] z2, x2, s2_y1;
  logic signed [CW-1:0] x3, y3, s3_z2;
  logic                 s3_sat;

  // Pitch: rotate (y, z), carry x
  evr_givens #(.CW(CW), .FB(TRIG_FRAC_BITS)) u_pitch (
    .clk     (clk),
    .rst_n   (rst_n),
    .trig    (pitch_r),
    .i_valid (in_vtx.valid),
    .i_ready (in_vtx.ready),
    .i_a     (in_vtx.y),
    .i_b     (in_vtx.z),
    .i_pass  (in_vtx.x),
    .i_sat   (1'b0),
    .o_valid (s1_valid),
    .o_ready (s1_ready),
    .o_p     (y1),
    .o_q     (z1),
    .o_pass  (s1_x),
    .o_sat   (s1_sat)
  );

  // Yaw: rotate (z1, x), carry y1
  evr_givens #(.CW(CW), .FB(TRIG_FRAC_BITS)) u_yaw (
    .clk     (clk),
    .rst_n   (rst_n),
    .trig    (yaw_r),
    .i_valid (s1_valid),
    .i_ready (s1_ready),
    .i_a     (z1),
    .i_b     (s1_x),
    .i_pass  (y1),
    .i_sat   (s1_sat),
    .o_valid (s2_valid),
    .o_ready (s2_ready),
    .o_p     (z2),
    .o_q     (x2),
    .o_pass  (s2_y1),
    .o_sat   (s2_sat)
  );

  // Roll: rotate (x2, y1), carry z2; its last stage is the result register
  evr_givens #(.CW(CW), .FB(TRIG_FRAC_BITS)) u_roll (
    .clk     (clk),
    .rst_n   (rst_n),
    .trig    (roll_r),
    .i_valid (s2_valid),
    .i_ready (s2_ready),
    .i_a     (x2),
    .i_b     (s2_y1),
    .i_pass  (z2),
    .i_sat   (s2_sat),
    .o_valid (out_rot.valid),
    .o_ready (out_rot.ready),
    .o_p     (x3),
    .o_q     (y3),
    .o_pass  (s3_z2),
    .o_sat   (s3_sat)
  );

  assign out_rot.x         = x3;
  assign out_rot.y         = y3;
  assign out_rot.z         = s3_z2;
  assign out_rot.saturated = s3_sat;

  // Track vertices in flight for the checks below
  logic [PIPE_CNT_W-1:0] inflight_r, inflight_nxt;
  logic                  in_fire, out_fire;

  assign in_fire  = in_vtx.valid && in_vtx.ready;
  assign out_fire = out_rot.valid && out_rot.ready;

  always_comb begin
    inflight_nxt = inflight_r;
    if (in_fire && !out_fire) begin
      inflight_nxt = inflight_r + PIPE_CNT_W'(1);
    end else if (!in_fire && out_fire) begin
      inflight_nxt = inflight_r - PIPE_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_nxt;
    end
  end

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_rot.valid)
    else $error("result valid right after reset");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= PIPE_CNT_W'(EVR_DEPTH))
    else $error("more vertices in flight than pipeline stages");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_rot.valid |-> inflight_r != '0)
    else $error("result offered with no vertex in flight");

  a_ready_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_vtx.ready |-> (out_rot.valid && !out_rot.ready
                       && inflight_r == PIPE_CNT_W'(EVR_DEPTH)))
    else $error("input refused while pipeline has room");

endmodule

// ----- sim/tb_euler_vertex_rotator_top.sv -----
// Self-checking bench for euler_vertex_rotator_top: streams vertices, predicts each rotation.
// Depends on evr_pkg, the channel interfaces in evr_if.sv and the rotator top level.
// Covers directed corners, random trig settings, random idling and a long output stall.
module tb_euler_vertex_rotator_top;
  import evr_pkg::*;

  localparam int     COORD_W     = 32;
  localparam int     FRAC_BITS   = 14;
  localparam longint COORD_MAX   = (longint'(1) <<< (COORD_W - 1)) - 1;
  localparam longint COORD_MIN   = -COORD_MAX - 1;
  localparam int     HOLD_CYCLES = 400;
  localparam int     RAND_PHASES = 8;
  localparam int     PHASE_ITEMS = 240;

  // Indexes past the last trig register; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  // Trig setting styles for the random phases
  localparam int TRIG_UNITISH = 0;
  localparam int TRIG_ANY     = 1;
  localparam int TRIG_CORNER  = 2;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } vertex_t;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      clipped;
  } rotated_t;

  logic clk;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [TRIG_W-1:0]    cfg_data;

  evr_vertex_if  #(.W(COORD_W)) vin  ();
  evr_rotated_if #(.W(COORD_W)) vout ();

  euler_vertex_rotator_top #(
    .COORD_WIDTH    (COORD_W),
    .TRIG_FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vtx    (vin),
    .out_rot   (vout),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Bench copy of the trig registers
  logic signed [TRIG_W-1:0] trig_q [0:5];

  vertex_t  vtx_pending_q [$];
  rotated_t rot_expect_q  [$];

  int  mismatch_cnt;
  int  tx_gap;
  int  rx_gap;
  bit  rx_hold;
  bit  pressure_go;
  bit  tail_quiet;

  vertex_t  drv_vtx;
  rotated_t mon_want;

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Round a Q2.14 product to nearest, ties toward plus infinity
  function automatic longint round_q14(longint prod);
    return (prod + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic longint clip_coord(longint v, inout bit clipped);
    if (v > COORD_MAX) begin
      clipped = 1'b1;
      return COORD_MAX;
    end
    if (v < COORD_MIN) begin
      clipped = 1'b1;
      return COORD_MIN;
    end
    return v;
  endfunction

  // Pitch about x, yaw about y, roll about z
  function automatic rotated_t rotate_vertex(vertex_t v);
    rotated_t r;
    bit       clipped;
    longint   x, y, z, cp, sp, cy, sy, cr, sr;
    longint   y1, z1, x2, z2, x3, y3;
    clipped = 1'b0;
    x  = v.x;
    y  = v.y;
    z  = v.z;
    cp = trig_q[REG_COS_PITCH];
    sp = trig_q[REG_SIN_PITCH];
    cy = trig_q[REG_COS_YAW];
    sy = trig_q[REG_SIN_YAW];
    cr = trig_q[REG_COS_ROLL];
    sr = trig_q[REG_SIN_ROLL];
    y1 = clip_coord(round_q14(y * cp) + round_q14(-(z * sp)), clipped);
    z1 = clip_coord(round_q14(y * sp) + round_q14(z * cp), clipped);
    x2 = clip_coord(round_q14(x * cy) + round_q14(z1 * sy), clipped);
    z2 = clip_coord(round_q14(-(x * sy)) + round_q14(z1 * cy), clipped);
    x3 = clip_coord(round_q14(x2 * cr) + round_q14(-(y1 * sr)), clipped);
    y3 = clip_coord(round_q14(x2 * sr) + round_q14(y1 * cr), clipped);
    r.x       = x3[COORD_W-1:0];
    r.y       = y3[COORD_W-1:0];
    r.z       = z2[COORD_W-1:0];
    r.clipped = clipped;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatch_cnt < 100)
      $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_cnt++;
  endtask

  // Input driver: present pending vertices, idle in random bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      vin.valid <= 1'b0;
      tx_gap    <= 0;
    end else begin
      if (vin.valid && vin.ready) begin
        drv_vtx = vtx_pending_q.pop_front();
        rot_expect_q.push_back(rotate_vertex(drv_vtx));
      end
      if (vin.valid && !vin.ready) begin
        // hold the offered transaction
      end else if (tx_gap > 0) begin
        tx_gap    <= tx_gap - 1;
        vin.valid <= 1'b0;
      end else if (!tail_quiet && $urandom_range(0, 9) == 0) begin
        tx_gap    <= $urandom_range(0, 14);
        vin.valid <= 1'b0;
      end else if (vtx_pending_q.size() > 0) begin
        vin.valid <= 1'b1;
        vin.x     <= vtx_pending_q[0].x;
        vin.y     <= vtx_pending_q[0].y;
        vin.z     <= vtx_pending_q[0].z;
      end else begin
        vin.valid <= 1'b0;
      end
    end
  end

  // Output monitor: check each transaction, stall in random bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      vout.ready <= 1'b0;
      rx_gap     <= 0;
    end else begin
      if (vout.valid && vout.ready) begin
        if (rot_expect_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result x=%h y=%h z=%h", vout.x, vout.y, vout.z));
        end else begin
          mon_want = rot_expect_q.pop_front();
          if (vout.x !== mon_want.x)
            report_mismatch($sformatf("x got %h want %h", vout.x, mon_want.x));
          if (vout.y !== mon_want.y)
            report_mismatch($sformatf("y got %h want %h", vout.y, mon_want.y));
          if (vout.z !== mon_want.z)
            report_mismatch($sformatf("z got %h want %h", vout.z, mon_want.z));
          if (vout.saturated !== mon_want.clipped)
            report_mismatch($sformatf("saturated got %b want %b",
                                      vout.saturated, mon_want.clipped));
        end
      end
      if (rx_hold) begin
        vout.ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap     <= rx_gap - 1;
        vout.ready <= 1'b0;
      end else if (!tail_quiet && $urandom_range(0, 11) == 0) begin
        rx_gap     <= $urandom_range(0, 14);
        vout.ready <= 1'b0;
      end else begin
        vout.ready <= 1'b1;
      end
    end
  end

  // Long output stall so the pipeline fills and back-pressures the input
  initial begin
    rx_hold = 1'b0;
    wait (pressure_go);
    @(negedge clk);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    rx_hold = 1'b0;
  end

  // Watchdog
  initial begin
    #6000000;
    $display("[euler_vertex_rotator_top] ERROR");
    $finish;
  end

  task automatic write_trig(logic [CFG_IDX_W-1:0] idx, logic [TRIG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx <= REG_SIN_ROLL)
      trig_q[idx] = val;
  endtask

  // Load all six registers, then release the write enable
  task automatic load_rotation(logic [TRIG_W-1:0] cp, logic [TRIG_W-1:0] sp,
                               logic [TRIG_W-1:0] cy, logic [TRIG_W-1:0] sy,
                               logic [TRIG_W-1:0] cr, logic [TRIG_W-1:0] sr);
    write_trig(REG_COS_PITCH, cp);
    write_trig(REG_SIN_PITCH, sp);
    write_trig(REG_COS_YAW,   cy);
    write_trig(REG_SIN_YAW,   sy);
    write_trig(REG_COS_ROLL,  cr);
    write_trig(REG_SIN_ROLL,  sr);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_spares();
    write_trig(REG_SPARE_LO, 16'($urandom));
    write_trig(REG_SPARE_HI, 16'($urandom));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_vertex(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                            logic [COORD_W-1:0] z);
    vertex_t v;
    v.x = x;
    v.y = y;
    v.z = z;
    vtx_pending_q.push_back(v);
  endtask

  // Wait until every vertex has come back, then let the pipeline go quiet
  task automatic drain();
    wait (vtx_pending_q.size() == 0 && rot_expect_q.size() == 0);
    repeat (EVR_DEPTH + 2) @(posedge clk);
  endtask

  function automatic logic [COORD_W-1:0] pick_coord();
    logic [COORD_W-1:0] corners [7];
    corners = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h1, 32'hffff_ffff,
                32'h0001_0000, 32'hffff_0000};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return COORD_W'(int'($urandom_range(0, 2097152)) - 1048576);
      7:          return COORD_W'(int'($urandom_range(0, 536870912)) - 268435456);
      default:    return corners[$urandom_range(0, 6)];
    endcase
  endfunction

  function automatic logic [TRIG_W-1:0] pick_trig(int style);
    logic [TRIG_W-1:0] corners [7];
    corners = '{16'h8000, 16'hc000, 16'h0000, 16'h4000, 16'h7fff, 16'h0001, 16'hffff};
    case (style)
      TRIG_UNITISH: return TRIG_W'(int'($urandom_range(0, 32768)) - 16384);
      TRIG_ANY:     return TRIG_W'($urandom);
      default:      return corners[$urandom_range(0, 6)];
    endcase
  endfunction

  // Stimulus
  initial begin
    int style;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    vin.valid    = 1'b0;
    vin.x        = '0;
    vin.y        = '0;
    vin.z        = '0;
    vout.ready   = 1'b0;
    mismatch_cnt = 0;
    pressure_go  = 1'b0;
    tail_quiet   = 1'b0;
    trig_q       = '{16'sd16384, 16'sd0, 16'sd16384, 16'sd0, 16'sd16384, 16'sd0};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Identity rotation out of reset: coordinate extremes pass unchanged
    @(negedge clk);
    add_vertex(32'h0, 32'h0, 32'h0);
    add_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    add_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    add_vertex(32'hffff_ffff, 32'h1, 32'hffff_ffff);
    add_vertex(32'h5555_5555, 32'haaaa_aaaa, 32'h0001_0000);
    drain();

    // Half-unit trig values: products land exactly on rounding ties
    write_spares();
    load_rotation(16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192);
    @(negedge clk);
    add_vertex(32'h1, 32'h1, 32'h1);
    add_vertex(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    add_vertex(32'h3, 32'hffff_fffd, 32'h5);
    add_vertex(32'h1, 32'h0, 32'hffff_ffff);
    add_vertex(32'h0, 32'hffff_ffff, 32'h1);
    drain();

    // Trig beyond unit magnitude: intermediate and final clipping
    load_rotation(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    @(negedge clk);
    add_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    add_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h0);
    add_vertex(32'h0001_0000, 32'hffff_0000, 32'h0002_0000);
    drain();

    // Most negative pattern everywhere
    load_rotation(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    @(negedge clk);
    add_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    add_vertex(32'h1, 32'hffff_ffff, 32'h2000);
    drain();

    // Trig values of exactly 0 and +-1 only: yaw is a quarter turn
    load_rotation(16'hc000, 16'h4000, 16'h0000, 16'h4000, 16'hc000, 16'hc000);
    @(negedge clk);
    add_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
    add_vertex(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    add_vertex(32'h8000_0000, 32'h0, 32'h7fff_ffff);
    drain();

    // Random phases, each under a fresh trig setting
    for (int p = 0; p < RAND_PHASES; p++) begin
      style = (p == RAND_PHASES - 1) ? TRIG_UNITISH : p % 3;
      if ($urandom_range(0, 2) == 0)
        write_spares();
      load_rotation(pick_trig(style), pick_trig(style), pick_trig(style),
                    pick_trig(style), pick_trig(style), pick_trig(style));
      @(negedge clk);
      if (p == 0)
        pressure_go = 1'b1;
      if (p == RAND_PHASES - 1)
        tail_quiet = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++)
        add_vertex(pick_coord(), pick_coord(), pick_coord());
      drain();
    end

    if (mismatch_cnt == 0)
      $display("[euler_vertex_rotator_top] OK");
    else
      $display("[euler_vertex_rotator_top] ERROR");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/evr_pkg.sv
hdl/evr_if.sv
hdl/evr_givens.sv
hdl/euler_vertex_rotator_top.sv
sim/tb_euler_vertex_rotator_top.sv
